// ----- rtl/accel_motion_tamper_detector_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the accelerometer motion and tamper detector
// Clocked implication checks used by the top-level detector.
// ----------------------------------------------------------------------------
`ifndef ACCEL_MOTION_TAMPER_DETECTOR_DEFINES_SVH
`define ACCEL_MOTION_TAMPER_DETECTOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AMTD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define AMTD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/amtd_pkg.sv -----
// ----------------------------------------------------------------------------
// amtd_pkg
// Shared widths, register map, result codes and control structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package amtd_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int THRESH_W    = 16;
    localparam int LIMIT_W     = 8;
    localparam int HOLD_W      = 4;
    localparam int SEQ_W       = 32;
    localparam int NUM_AXES    = 3;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 4;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd64;
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 8'd3;
    localparam logic [HOLD_W-1:0]   HOLD_RESET   = 4'd5;

    // Register word index (paddr[3:2])
    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_LIMIT     = 2'd1;
    localparam logic [1:0] REG_HOLD      = 2'd2;

    typedef enum logic [1:0] {
        WAIT_WARMUP = 2'd0,
        WAIT_TAMPER = 2'd1,
        WAIT_IDLE   = 2'd2
    } t_wait_kind;

    // Per-stage advance strobes for the axis lanes
    typedef struct packed {
        logic load;
        logic adv2;
        logic adv3;
    } t_lane_ctl;

    // Item classification carried down the pipeline
    typedef struct packed {
        logic warm;
        logic arm_now;
        logic check;
    } t_item_flags;

endpackage

`default_nettype wire

// ----- rtl/accel_motion_tamper_detector.sv -----
// ----------------------------------------------------------------------------
// accel_motion_tamper_detector
// Moving-average motion and tamper detector for a three-axis accelerometer.
//
//   Channel   Direction  Handshake                  Payload
//   input     in         i_in_valid / o_in_ready    i_accel_x, i_accel_y, i_accel_z
//   output    out        o_out_valid / i_out_ready  o_sequence_number .. o_wait_kind
//   config    in         psel / penable / pready    paddr, pwdata, prdata
//
// One sample per cycle unless output back-pressure has filled the pipeline.
// Three axis lanes (ring, sum, reciprocal multiply, compare) feed one merge
// stage that owns the tamper hold, movement count and output register.
// Synchronous reset clears the ring, sums and counters.
// Each stage holds while the one after it is full and stalled; empty stages
// still take new samples.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "accel_motion_tamper_detector_defines.svh"

module accel_motion_tamper_detector
    import amtd_pkg::*;
#(
    parameter int WINDOW_DEPTH = 10
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_in_valid,
    output logic                       o_in_ready,
    input  wire signed [SAMPLE_W-1:0]  i_accel_x,
    input  wire signed [SAMPLE_W-1:0]  i_accel_y,
    input  wire signed [SAMPLE_W-1:0]  i_accel_z,
    output logic                       o_out_valid,
    input  wire                        i_out_ready,
    output logic [SEQ_W-1:0]           o_sequence_number,
    output logic [LIMIT_W-1:0]         o_reported_moving,
    output logic                       o_armed_now,
    output logic                       o_tamper_active,
    output logic                       o_alarm,
    output logic [1:0]                 o_wait_kind,
    input  wire                        psel,
    input  wire                        penable,
    input  wire                        pwrite,
    input  wire  [APB_ADDR_W-1:0]      paddr,
    input  wire  [APB_DATA_W-1:0]      pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready
);

    localparam int PW = $clog2(WINDOW_DEPTH);
    localparam logic [PW-1:0] LAST_POS = PW'(WINDOW_DEPTH - 1);

    logic [THRESH_W-1:0] r_threshold;
    logic [LIMIT_W-1:0]  r_limit;
    logic [HOLD_W-1:0]   r_hold;

    logic [PW-1:0]       r_pos;
    logic                r_armed;
    logic                r_v1;
    logic                r_v2;
    logic                r_v3;
    t_item_flags         r_flags1;
    t_item_flags         r_flags2;
    t_item_flags         r_flags3;

    logic                w_rdy_o;
    logic                w_rdy1;
    logic                w_rdy2;
    logic                w_rdy3;
    logic                w_load;
    logic                w_wrap;
    logic                w_cfg_wr;
    t_lane_ctl           w_ctl;
    t_item_flags         w_flags;
    logic [NUM_AXES-1:0] w_dev;
    logic signed [SAMPLE_W-1:0] w_samples [NUM_AXES];

    // Configuration registers
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESH_RESET;
            r_limit     <= LIMIT_RESET;
            r_hold      <= HOLD_RESET;
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                REG_THRESHOLD: r_threshold <= pwdata[THRESH_W-1:0];
                REG_LIMIT:     r_limit     <= pwdata[LIMIT_W-1:0];
                REG_HOLD:      r_hold      <= pwdata[HOLD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_THRESHOLD: prdata = APB_DATA_W'(r_threshold);
            REG_LIMIT:     prdata = APB_DATA_W'(r_limit);
            REG_HOLD:      prdata = APB_DATA_W'(r_hold);
            default:       prdata = '0;
        endcase
    end

    // Stage occupancy and backpressure
    assign w_rdy3     = !r_v3 || w_rdy_o;
    assign w_rdy2     = !r_v2 || w_rdy3;
    assign w_rdy1     = !r_v1 || w_rdy2;
    assign o_in_ready = w_rdy1;
    assign w_load     = i_in_valid && w_rdy1;

    assign w_ctl.load = w_load;
    assign w_ctl.adv2 = w_rdy2 && r_v1;
    assign w_ctl.adv3 = w_rdy3 && r_v2;

    // Warm-up until the ring wraps for the first time
    assign w_wrap          = (r_pos == LAST_POS);
    assign w_flags.warm    = !r_armed && !w_wrap;
    assign w_flags.arm_now = !r_armed && w_wrap;
    assign w_flags.check   = r_armed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_armed <= 1'b0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
        end else begin
            if (w_load) begin
                r_pos <= w_wrap ? '0 : r_pos + 1'b1;
                if (w_wrap) begin
                    r_armed <= 1'b1;
                end
            end
            if (w_rdy1) begin
                r_v1 <= i_in_valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.load) begin
            r_flags1 <= w_flags;
        end
        if (w_ctl.adv2) begin
            r_flags2 <= r_flags1;
        end
        if (w_ctl.adv3) begin
            r_flags3 <= r_flags2;
        end
    end

    assign w_samples[0] = i_accel_x;
    assign w_samples[1] = i_accel_y;
    assign w_samples[2] = i_accel_z;

    for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
        amtd_lane #(
            .WINDOW_DEPTH (WINDOW_DEPTH)
        ) u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_slot      (r_pos),
            .i_sample    (w_samples[g]),
            .i_threshold (r_threshold),
            .o_dev       (w_dev[g])
        );
    end

    amtd_merge u_merge (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (r_v3),
        .i_flags           (r_flags3),
        .i_dev             (w_dev),
        .i_limit           (r_limit),
        .i_hold            (r_hold),
        .i_out_ready       (i_out_ready),
        .o_ready           (w_rdy_o),
        .o_out_valid       (o_out_valid),
        .o_sequence_number (o_sequence_number),
        .o_reported_moving (o_reported_moving),
        .o_armed_now       (o_armed_now),
        .o_tamper_active   (o_tamper_active),
        .o_alarm           (o_alarm),
        .o_wait_kind       (o_wait_kind)
    );

    `AMTD_ASSERT_NEXT(a_armed_sticks, i_clk, i_rst_n, r_armed, r_armed)

    `AMTD_ASSERT_IMPL(a_pos_in_ring, i_clk, i_rst_n, 1'b1, r_pos <= LAST_POS)

    `AMTD_ASSERT_IMPL(a_alarm_needs_tamper, i_clk, i_rst_n, o_out_valid && o_alarm, o_tamper_active)

    `AMTD_ASSERT_IMPL(a_take_when_empty, i_clk, i_rst_n, !r_v1, o_in_ready)

endmodule

`default_nettype wire

// ----- rtl/amtd_lane.sv -----
// ----------------------------------------------------------------------------
// amtd_lane
// One axis: sample ring, running sum, mean by reciprocal multiply and the
// deviation compare, in three stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module amtd_lane
    import amtd_pkg::*;
#(
    parameter int WINDOW_DEPTH = 10
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  t_lane_ctl                             i_ctl,
    input  wire        [$clog2(WINDOW_DEPTH)-1:0] i_slot,
    input  wire signed [SAMPLE_W-1:0]             i_sample,
    input  wire        [THRESH_W-1:0]             i_threshold,
    output logic                                  o_dev
);

    localparam int DEPTH_LOG = $clog2(WINDOW_DEPTH);
    localparam int SUM_W     = SAMPLE_W + DEPTH_LOG;
    localparam int SHIFT     = SUM_W + DEPTH_LOG;
    localparam int MUL_W     = SUM_W + 1;
    localparam int PROD_W    = SUM_W + MUL_W;
    localparam int DIF_W     = SUM_W + 1;
    localparam logic [63:0] MulFull =
        ((64'd1 << SHIFT) + 64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH);
    localparam logic [MUL_W-1:0] MUL_K = MulFull[MUL_W-1:0];

    logic signed [SAMPLE_W-1:0] r_ring [WINDOW_DEPTH];
    logic signed [SUM_W-1:0]    r_sum;

    logic signed [SUM_W-1:0]    r_sum1;
    logic signed [SAMPLE_W-1:0] r_s1;
    logic [PROD_W-1:0]          r_prod2;
    logic                       r_neg2;
    logic signed [SAMPLE_W-1:0] r_s2;
    logic                       r_dev3;

    logic signed [SUM_W-1:0]    w_sum_new;
    logic [SUM_W-1:0]           w_mag;
    logic [PROD_W-1:0]          w_prod;
    logic [SUM_W-1:0]           w_q;
    logic signed [DIF_W-1:0]    w_mean;
    logic signed [DIF_W-1:0]    w_diff;
    logic [DIF_W-1:0]           w_adiff;

    // Stage 1: retire the oldest sample of this slot, add the new one
    assign w_sum_new = r_sum + SUM_W'(i_sample) - SUM_W'(r_ring[i_slot]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WINDOW_DEPTH; k++) begin
                r_ring[k] <= '0;
            end
            r_sum <= '0;
        end else if (i_ctl.load) begin
            r_ring[i_slot] <= i_sample;
            r_sum          <= w_sum_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_sum1 <= w_sum_new;
            r_s1   <= i_sample;
        end
    end

    // Stage 2: magnitude times reciprocal of the window depth
    assign w_mag  = r_sum1[SUM_W-1] ? SUM_W'(-r_sum1) : SUM_W'(r_sum1);
    assign w_prod = PROD_W'(w_mag) * PROD_W'(MUL_K);

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv2) begin
            r_prod2 <= w_prod;
            r_neg2  <= r_sum1[SUM_W-1];
            r_s2    <= r_s1;
        end
    end

    // Stage 3: restore the sign (truncate toward zero), compare distance
    assign w_q     = SUM_W'(r_prod2 >> SHIFT);
    assign w_mean  = r_neg2 ? -$signed({1'b0, w_q}) : $signed({1'b0, w_q});
    assign w_diff  = w_mean - DIF_W'(r_s2);
    assign w_adiff = w_diff[DIF_W-1] ? DIF_W'(-w_diff) : DIF_W'(w_diff);

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv3) begin
            r_dev3 <= (w_adiff >= DIF_W'(i_threshold));
        end
    end

    assign o_dev = r_dev3;

endmodule

`default_nettype wire

// ----- rtl/amtd_merge.sv -----
// ----------------------------------------------------------------------------
// amtd_merge
// Combines the lane deviation flags, runs the tamper hold and movement
// count, and holds the result in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module amtd_merge
    import amtd_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    input  t_item_flags          i_flags,
    input  wire [NUM_AXES-1:0]   i_dev,
    input  wire [LIMIT_W-1:0]    i_limit,
    input  wire [HOLD_W-1:0]     i_hold,
    input  wire                  i_out_ready,
    output logic                 o_ready,
    output logic                 o_out_valid,
    output logic [SEQ_W-1:0]     o_sequence_number,
    output logic [LIMIT_W-1:0]   o_reported_moving,
    output logic                 o_armed_now,
    output logic                 o_tamper_active,
    output logic                 o_alarm,
    output logic [1:0]           o_wait_kind
);

    logic               r_vo;
    logic [SEQ_W-1:0]   r_counter;
    logic [HOLD_W-1:0]  r_tamper;
    logic [LIMIT_W-1:0] r_moving;

    logic [SEQ_W-1:0]   r_seq;
    logic [LIMIT_W-1:0] r_moving_rep;
    logic               r_arm_now;
    logic               r_active;
    logic               r_alarm;
    t_wait_kind         r_wait;

    logic               w_take;
    logic [HOLD_W-1:0]  w_hold_eff;
    logic [HOLD_W-1:0]  n_tamper;
    logic [LIMIT_W-1:0] n_moving;
    logic               n_active;
    logic               n_alarm;
    t_wait_kind         n_wait;

    assign o_ready = !r_vo || i_out_ready;
    assign w_take  = i_valid && o_ready;

    always_comb begin
        w_hold_eff = (i_flags.check && (|i_dev)) ? i_hold : r_tamper;
        n_tamper   = r_tamper;
        n_moving   = r_moving;
        n_active   = 1'b0;
        n_alarm    = 1'b0;
        n_wait     = WAIT_WARMUP;
        if (!i_flags.warm) begin
            if (w_hold_eff != '0) begin
                n_active = 1'b1;
                n_wait   = WAIT_TAMPER;
                n_tamper = w_hold_eff - 1'b1;
                if (r_moving < i_limit) begin
                    n_moving = r_moving + 1'b1;
                end else begin
                    n_alarm = 1'b1;
                end
            end else begin
                n_wait   = WAIT_IDLE;
                n_tamper = w_hold_eff;
                n_moving = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo      <= 1'b0;
            r_counter <= '0;
            r_tamper  <= '0;
            r_moving  <= '0;
        end else begin
            if (o_ready) begin
                r_vo <= i_valid;
            end
            if (w_take) begin
                r_counter <= r_counter + 1'b1;
                r_tamper  <= n_tamper;
                r_moving  <= n_moving;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_seq        <= r_counter;
            r_moving_rep <= r_moving;
            r_arm_now    <= i_flags.arm_now;
            r_active     <= n_active;
            r_alarm      <= n_alarm;
            r_wait       <= n_wait;
        end
    end

    assign o_out_valid       = r_vo;
    assign o_sequence_number = r_seq;
    assign o_reported_moving = r_moving_rep;
    assign o_armed_now       = r_arm_now;
    assign o_tamper_active   = r_active;
    assign o_alarm           = r_alarm;
    assign o_wait_kind       = r_wait;

endmodule

`default_nettype wire
